// ===== hw/rtl/epp_pkg.sv =====
package epp_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned SkipW  = 5;
  localparam int unsigned TickW  = 17;
  localparam int unsigned TimeW  = 16;

  localparam logic [PhaseW-1:0] PH_SYNC1   = 3'd0;
  localparam logic [PhaseW-1:0] PH_SYNC2   = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN     = 3'd2;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PhaseW-1:0] PH_CHECK   = 3'd4;

  localparam logic [ModeW-1:0] FM_CODE = 3'd0;
  localparam logic [ModeW-1:0] FM_QUAL = 3'd1;
  localparam logic [ModeW-1:0] FM_ATT  = 3'd2;
  localparam logic [ModeW-1:0] FM_MED  = 3'd3;
  localparam logic [ModeW-1:0] FM_SKIP = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] SYNC_BYTE       = 8'd170;
  localparam logic [7:0] MAX_LEN         = 8'd169;
  localparam logic [7:0] DEFAULT_QUALITY = 8'd200;
  localparam logic [7:0] CODE_QUAL       = 8'd2;
  localparam logic [7:0] CODE_ATT        = 8'd4;
  localparam logic [7:0] CODE_MED        = 8'd5;
  localparam logic [7:0] CODE_SKIP_S     = 8'h80;
  localparam logic [7:0] CODE_SKIP_L     = 8'h83;
  localparam logic [SkipW-1:0] SKIP_S_LEN = 5'd3;
  localparam logic [SkipW-1:0] SKIP_L_LEN = 5'd25;
  localparam logic [TimeW-1:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [TickW-1:0] TICK_MAX = {TickW{1'b1}};

  typedef struct packed {
    logic       command;
    logic [7:0] data;
  } epp_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] quality;
    logic [7:0] attention_level;
    logic [7:0] meditation_level;
    logic       quality_seen;
  } epp_result_t;

endpackage

// ===== hw/rtl/epp_in_if.sv =====
interface epp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data;

  modport source (output valid, output command, output data, input ready);
  modport sink (input valid, input command, input data, output ready);
endinterface

// ===== hw/rtl/epp_out_if.sv =====
interface epp_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] quality;
  logic [7:0] attention_level;
  logic [7:0] meditation_level;
  logic       quality_seen;

  modport source (output valid, output status, output quality, output attention_level,
                  output meditation_level, output quality_seen, input ready);
  modport sink (input valid, input status, input quality, input attention_level,
                input meditation_level, input quality_seen, output ready);
endinterface

// ===== hw/rtl/epp_in_stage.sv =====
module epp_in_stage
  import epp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  epp_item_t in_item,
  input  logic      advance,
  output logic      item_valid,
  output epp_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  epp_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/epp_parser.sv =====
module epp_parser
  import epp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TimeW-1:0]  cfg_wr_data,
  input  logic              take,
  input  epp_item_t         item,
  output logic              emit,
  output epp_result_t       result
);

  logic [TimeW-1:0]  timeout_r, timeout_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [ModeW-1:0]  mode_r, mode_nxt;
  logic [SkipW-1:0]  skip_r, skip_nxt;
  logic [7:0]        qual_r, qual_nxt;
  logic [7:0]        att_r, att_nxt;
  logic [7:0]        med_r, med_nxt;
  logic              flag_r, flag_nxt;
  logic [TickW-1:0]  ticks_r, ticks_nxt;
  logic              sum_good;
  logic              timed_out;
  logic              last_byte;

  assign sum_good  = (item.data == ~sum_r);
  assign timed_out = !flag_r && (ticks_r > {1'b0, timeout_r});
  assign last_byte = (left_r == 8'd1);
  assign emit      = (item.command == CMD_BYTE) && (phase_r == PH_CHECK);

  always_comb begin
    result = '0;
    if (!sum_good) begin
      result.status = 1'b1;
    end else if (timed_out) begin
      result.quality = DEFAULT_QUALITY;
    end else begin
      result.quality          = qual_r;
      result.attention_level  = att_r;
      result.meditation_level = med_r;
      result.quality_seen     = flag_r;
    end
  end

  always_comb begin
    timeout_nxt = cfg_wr_en ? cfg_wr_data : timeout_r;
    phase_nxt   = phase_r;
    left_nxt    = left_r;
    sum_nxt     = sum_r;
    mode_nxt    = mode_r;
    skip_nxt    = skip_r;
    qual_nxt    = qual_r;
    att_nxt     = att_r;
    med_nxt     = med_r;
    flag_nxt    = flag_r;
    ticks_nxt   = ticks_r;
    if (take) begin
      if (item.command == CMD_TICK) begin
        if (ticks_r != TICK_MAX) begin
          ticks_nxt = ticks_r + 1'b1;
        end
      end else begin
        case (phase_r)
          PH_SYNC1: begin
            if (item.data == SYNC_BYTE) begin
              phase_nxt = PH_SYNC2;
            end
          end
          PH_SYNC2: begin
            phase_nxt = (item.data == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
          end
          PH_LEN: begin
            if (item.data > MAX_LEN) begin
              phase_nxt = PH_SYNC1;
            end else begin
              left_nxt  = item.data;
              sum_nxt   = '0;
              mode_nxt  = FM_CODE;
              skip_nxt  = '0;
              qual_nxt  = DEFAULT_QUALITY;
              att_nxt   = '0;
              med_nxt   = '0;
              flag_nxt  = 1'b0;
              phase_nxt = (item.data == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            sum_nxt  = sum_r + item.data;
            left_nxt = left_r - 1'b1;
            case (mode_r)
              FM_QUAL: begin
                qual_nxt = item.data;
                flag_nxt = 1'b1;
                mode_nxt = FM_CODE;
              end
              FM_ATT: begin
                att_nxt  = item.data;
                mode_nxt = FM_CODE;
              end
              FM_MED: begin
                med_nxt  = item.data;
                mode_nxt = FM_CODE;
              end
              FM_SKIP: begin
                skip_nxt = skip_r - 1'b1;
                if (skip_r == 5'd1) begin
                  mode_nxt = FM_CODE;
                end
              end
              default: begin
                if (!last_byte) begin
                  if (item.data == CODE_QUAL) begin
                    mode_nxt = FM_QUAL;
                  end else if (item.data == CODE_ATT) begin
                    mode_nxt = FM_ATT;
                  end else if (item.data == CODE_MED) begin
                    mode_nxt = FM_MED;
                  end else if (item.data == CODE_SKIP_S) begin
                    mode_nxt = FM_SKIP;
                    skip_nxt = SKIP_S_LEN;
                  end else if (item.data == CODE_SKIP_L) begin
                    mode_nxt = FM_SKIP;
                    skip_nxt = SKIP_L_LEN;
                  end
                end
              end
            endcase
            if (last_byte) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_nxt = PH_SYNC1;
            if (sum_good && flag_r) begin
              ticks_nxt = '0;
            end
          end
          default: begin
            phase_nxt = PH_SYNC1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      phase_r   <= PH_SYNC1;
      left_r    <= '0;
      sum_r     <= '0;
      mode_r    <= FM_CODE;
      skip_r    <= '0;
      qual_r    <= DEFAULT_QUALITY;
      att_r     <= '0;
      med_r     <= '0;
      flag_r    <= 1'b0;
      ticks_r   <= '0;
    end else begin
      timeout_r <= timeout_nxt;
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      sum_r     <= sum_nxt;
      mode_r    <= mode_nxt;
      skip_r    <= skip_nxt;
      qual_r    <= qual_nxt;
      att_r     <= att_nxt;
      med_r     <= med_nxt;
      flag_r    <= flag_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

endmodule

// ===== hw/rtl/epp_out_stage.sv =====
module epp_out_stage
  import epp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  epp_result_t result,
  output logic        room,
  output logic        out_valid,
  input  logic        out_ready,
  output epp_result_t out_result
);

  logic        valid_r;
  logic        valid_nxt;
  epp_result_t result_r;

  assign room      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== hw/rtl/eeg_headset_packet_parser_unit.sv =====
// channel  dir  payload                                                      width
// in_ch    in   command, data                                                1+8
// out_ch   out  status, quality, attention_level, meditation_level, q_seen   1+8+8+8+1
// cfg      in   cfg_wr_en, cfg_wr_data (timeout_ms)                          16
//
// one word per cycle while no stall holds it; a word goes input register -> parser ->
// result register, and a result is loaded there as the parser takes its checksum word
// rst_n synchronous, active low; timeout back to 5000 ticks, parser hunting sync
// a result held in the result register stalls only words that would produce a
// result; the input register then holds one word and in_ch.ready drops
module eeg_headset_packet_parser_unit
  import epp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  epp_in_if.sink            in_ch,
  epp_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [TimeW-1:0]  cfg_wr_data
);

  epp_item_t   in_item;
  epp_item_t   item;
  epp_result_t result;
  epp_result_t out_result;
  logic        item_valid;
  logic        advance;
  logic        emit;
  logic        room;
  logic        out_valid;

  assign in_item.command = in_ch.command;
  assign in_item.data    = in_ch.data;
  assign advance         = item_valid && (!emit || room);

  epp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  epp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (advance),
    .item        (item),
    .emit        (emit),
    .result      (result)
  );

  epp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && emit),
    .result     (result),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.valid            = out_valid;
  assign out_ch.status           = out_result.status;
  assign out_ch.quality          = out_result.quality;
  assign out_ch.attention_level  = out_result.attention_level;
  assign out_ch.meditation_level = out_result.meditation_level;
  assign out_ch.quality_seen     = out_result.quality_seen;

endmodule
